FILE: rtl/ft12fb_pkg.sv
`default_nettype none

package ft12fb_pkg;

  // Frame characters.
  localparam logic [7:0] StartVar  = 8'h68;
  localparam logic [7:0] StartFix  = 8'h10;
  localparam logic [7:0] CtrlTog1  = 8'h73;
  localparam logic [7:0] CtrlTog0  = 8'h53;
  localparam logic [7:0] CtrlReset = 8'h40;
  localparam logic [7:0] EndChar   = 8'h16;

  // Input kind carried on tuser bit 0.
  localparam logic CmdReset = 1'b0;
  localparam logic CmdData  = 1'b1;

  // Byte positions inside a variable-length frame.
  // A reset frame uses positions 0 to 3 of its own sequence.
  localparam logic [2:0] PosStart0 = 3'd0;
  localparam logic [2:0] PosLen0   = 3'd1;
  localparam logic [2:0] PosLen1   = 3'd2;
  localparam logic [2:0] PosStart1 = 3'd3;
  localparam logic [2:0] PosCtrl   = 3'd4;
  localparam logic [2:0] PosData   = 3'd5;
  localparam logic [2:0] PosSum    = 3'd6;
  localparam logic [2:0] PosEnd    = 3'd7;
  localparam logic [2:0] PosRstEnd = 3'd3;

  // Job queue geometry.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // One classified item, ready for byte emission.
  typedef struct packed {
    logic       is_reset;
    logic       first;
    logic       final_b;
    logic [7:0] lfield;
    logic [7:0] ctrl;
    logic [7:0] data;
    logic [7:0] sum;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ft12_frame_builder_unit.sv
// FT1.2 frame builder.
//
// Input stream (s_axis): one item per transfer. tuser bit 0 selects a reset
// frame (0) or a payload byte (1); tuser bit 1 marks the first payload byte
// of a frame, tlast the last one. tdata carries the payload byte and the
// frame length, which is read only with the first byte.
// Output stream (m_axis): one frame byte per transfer in tdata; tlast marks
// the last byte that a given input item produced.
// A reset item yields 4 bytes, a mid-frame byte 1, a first byte 6, a last
// byte 3, and a byte that both opens and closes a frame 8.
// An input item is written into the job queue; when the queue was empty, the
// sequencer then registers its first output byte. The byte sequencer emits one
// byte per cycle while the receiver accepts, so sustained throughput is one
// output byte per cycle; mid-frame items flow at one per cycle, and header or
// trailer bursts are absorbed by a 4-entry job queue. s_axis_tready drops only
// while that queue is full. Reset clears the toggle bit, the checksum, the
// queue and the output valid flag. When the receiver holds m_axis_tready low,
// the current byte stays on the port and the queue fills behind it.
`default_nettype none

module ft12_frame_builder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] data_byte, [15:8] frame_length
  input  wire logic [1:0]  s_axis_tuser,  // [0] cmd, [1] first_byte
  input  wire logic        s_axis_tlast,  // final_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic             m_axis_tlast   // run_end
);

  logic                   in_xfer;
  logic                   pop;
  logic                   busy;
  ft12fb_pkg::job_t       new_job;
  ft12fb_pkg::job_t       head_job;
  ft12fb_pkg::fifo_stat_t q_stat;

  assign s_axis_tready = !q_stat.full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Classify items and keep frame state.
  ft12fb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_xfer),
    .cmd_i          (s_axis_tuser[0]),
    .data_byte_i    (s_axis_tdata[7:0]),
    .frame_length_i (s_axis_tdata[15:8]),
    .first_byte_i   (s_axis_tuser[1]),
    .final_byte_i   (s_axis_tlast),
    .job_o          (new_job)
  );

  // Job queue between the two sides.
  ft12fb_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_xfer),
    .push_job_i (new_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  // Byte sequencer and output register.
  ft12fb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .head_valid_i (!q_stat.empty),
    .pop_o        (pop),
    .busy_o       (busy),
    .out_valid_o  (m_axis_tvalid),
    .out_byte_o   (m_axis_tdata),
    .run_end_o    (m_axis_tlast),
    .out_ready_i  (m_axis_tready)
  );

  // A pushed job stays queued at least until the next edge.
  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !q_stat.empty)
    else $error("queue empty right after an input transfer");

  // The sequencer only works on a queued job.
  a_busy_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !q_stat.empty)
    else $error("sequencer busy with an empty queue");

  // A pop only happens while the queue holds a job.
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/ft12fb_front.sv
`default_nettype none

module ft12fb_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              cmd_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic [7:0]        frame_length_i,
  input  wire logic              first_byte_i,
  input  wire logic              final_byte_i,
  output ft12fb_pkg::job_t       job_o
);

  logic       toggle_q, toggle_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] ctrl;
  logic [7:0] base;
  logic [7:0] new_sum;

  // Control byte and checksum for the incoming byte.
  assign ctrl    = toggle_q ? ft12fb_pkg::CtrlTog1 : ft12fb_pkg::CtrlTog0;
  assign base    = first_byte_i ? ctrl : sum_q;
  assign new_sum = base + data_byte_i;

  // Next toggle and sum state on a transfer.
  always_comb begin
    toggle_d = toggle_q;
    sum_d    = sum_q;
    if (accept_i) begin
      if (cmd_i == ft12fb_pkg::CmdReset) begin
        toggle_d = 1'b1;
      end else begin
        sum_d = new_sum;
        if (first_byte_i) begin
          toggle_d = ~toggle_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_q <= 1'b0;
      sum_q    <= 8'h00;
    end else begin
      toggle_q <= toggle_d;
      sum_q    <= sum_d;
    end
  end

  // Job descriptor handed to the queue.
  always_comb begin
    job_o.is_reset = (cmd_i == ft12fb_pkg::CmdReset);
    job_o.first    = first_byte_i;
    job_o.final_b  = final_byte_i;
    job_o.lfield   = frame_length_i + 8'd1;
    job_o.ctrl     = ctrl;
    job_o.data     = data_byte_i;
    job_o.sum      = new_sum;
  end

endmodule

`default_nettype wire

FILE: rtl/ft12fb_fifo.sv
`default_nettype none

module ft12fb_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire ft12fb_pkg::job_t     push_job_i,
  input  wire logic                 pop_i,
  output ft12fb_pkg::job_t          head_o,
  output ft12fb_pkg::fifo_stat_t    stat_o
);

  ft12fb_pkg::job_t mem_q [ft12fb_pkg::FifoDepth];
  logic [ft12fb_pkg::FifoAw:0] wr_ptr_q, wr_ptr_d;
  logic [ft12fb_pkg::FifoAw:0] rd_ptr_q, rd_ptr_d;

  // Status from the pointer pair; the top bit tells wrap.
  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  assign stat_o.full  =
    (wr_ptr_q[ft12fb_pkg::FifoAw] != rd_ptr_q[ft12fb_pkg::FifoAw]) &&
    (wr_ptr_q[ft12fb_pkg::FifoAw-1:0] == rd_ptr_q[ft12fb_pkg::FifoAw-1:0]);

  assign head_o = mem_q[rd_ptr_q[ft12fb_pkg::FifoAw-1:0]];

  assign wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[ft12fb_pkg::FifoAw-1:0]] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ft12fb_back.sv
`default_nettype none

module ft12fb_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ft12fb_pkg::job_t  head_i,
  input  wire logic              head_valid_i,
  output logic                   pop_o,
  output logic                   busy_o,
  output logic                   out_valid_o,
  output logic [7:0]             out_byte_o,
  output logic                   run_end_o,
  input  wire logic              out_ready_i
);

  logic       busy_q, busy_d;
  logic [2:0] pos_q, pos_d;
  logic [2:0] start_pos;
  logic [2:0] end_pos;
  logic [2:0] cur_pos;
  logic       last;
  logic       emit;
  logic [7:0] cur_byte;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       run_end_q;

  // First and last byte position of the head job.
  always_comb begin
    if (head_i.is_reset) begin
      start_pos = ft12fb_pkg::PosStart0;
      end_pos   = ft12fb_pkg::PosRstEnd;
    end else begin
      start_pos = head_i.first   ? ft12fb_pkg::PosStart0 : ft12fb_pkg::PosData;
      end_pos   = head_i.final_b ? ft12fb_pkg::PosEnd    : ft12fb_pkg::PosData;
    end
  end

  assign cur_pos = busy_q ? pos_q : start_pos;
  assign last    = (cur_pos == end_pos);
  assign emit    = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o   = emit && last;
  assign busy_o  = busy_q;

  // Byte at the current position.
  always_comb begin
    if (head_i.is_reset) begin
      unique case (cur_pos) inside
        ft12fb_pkg::PosStart0: cur_byte = ft12fb_pkg::StartFix;
        ft12fb_pkg::PosRstEnd: cur_byte = ft12fb_pkg::EndChar;
        default:               cur_byte = ft12fb_pkg::CtrlReset;
      endcase
    end else begin
      unique case (cur_pos) inside
        ft12fb_pkg::PosStart0, ft12fb_pkg::PosStart1: cur_byte = ft12fb_pkg::StartVar;
        ft12fb_pkg::PosLen0, ft12fb_pkg::PosLen1:     cur_byte = head_i.lfield;
        ft12fb_pkg::PosCtrl:                          cur_byte = head_i.ctrl;
        ft12fb_pkg::PosData:                          cur_byte = head_i.data;
        ft12fb_pkg::PosSum:                           cur_byte = head_i.sum;
        default:                                      cur_byte = ft12fb_pkg::EndChar;
      endcase
    end
  end

  // Sequencer position across one job.
  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (emit) begin
      busy_d = !last;
      pos_d  = cur_pos + 3'd1;
    end
  end

  // Output register drains on a transfer and refills on an emit.
  assign valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q    <= cur_byte;
      run_end_q <= last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign run_end_o   = run_end_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  // One input item as the frame builder sees it.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic [7:0] flen;
    logic       first;
    logic       fin;
  } item_t;

  // One expected output byte and its end-of-run flag.
  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
  } frame_byte_t;

  // Directed row: the item, and optionally the bytes it must produce.
  // Typed bytes are packed first byte in the top bits; zero count means predicted.
  typedef struct packed {
    item_t       item;
    logic [3:0]  n_typed;
    logic [63:0] typed;
  } dir_row_t;

  localparam int unsigned NumDir    = 16;
  localparam int unsigned NumItems  = 360;
  localparam int unsigned DrainWait = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [7:0] data_byte, [15:8] frame_length
  logic [1:0]  s_axis_tuser = '0;  // [0] cmd, [1] first_byte
  logic        s_axis_tlast = 1'b0;  // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // [7:0] out_byte
  logic        m_axis_tlast;  // run_end

  // Predicted frame state.
  logic        toggle_q;
  logic [7:0]  sum_q;

  frame_byte_t frame_byte_q[$];
  dir_row_t    dir_tab [NumDir];
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  ft12_frame_builder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_count++;
    $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Work out the bytes one item produces and advance the frame state.
  // The bytes come back packed with the first byte in the top bits.
  function automatic int unsigned build_frame_bytes(input item_t it,
                                                    output logic [63:0] seq);
    int unsigned n;
    logic [7:0]  lfield;
    logic [7:0]  ctrl;
    seq = '0;
    n = 0;
    if (it.cmd == ft12fb_pkg::CmdReset) begin
      seq[63:32] = {ft12fb_pkg::StartFix, ft12fb_pkg::CtrlReset, ft12fb_pkg::CtrlReset,
                    ft12fb_pkg::EndChar};
      n = 4;
      toggle_q = 1'b1;
    end else begin
      // An opening byte is preceded by the header and restarts the checksum.
      if (it.first) begin
        lfield = it.flen + 8'd1;
        ctrl = toggle_q ? ft12fb_pkg::CtrlTog1 : ft12fb_pkg::CtrlTog0;
        seq[63:24] = {ft12fb_pkg::StartVar, lfield, lfield, ft12fb_pkg::StartVar, ctrl};
        n = 5;
        toggle_q = ~toggle_q;
        sum_q = ctrl;
      end
      seq[63-8*n -: 8] = it.data;
      n++;
      sum_q = sum_q + it.data;
      if (it.fin) begin
        seq[63-8*n -: 8] = sum_q;
        seq[55-8*n -: 8] = ft12fb_pkg::EndChar;
        n += 2;
      end
    end
    return n;
  endfunction

  // Drive one item after a random gap and queue its bytes once it is taken.
  task automatic send_item(input item_t it, input int unsigned n_typed,
                           input logic [63:0] typed);
    int unsigned gap;
    int unsigned n;
    int unsigned i;
    logic [63:0] seq;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.flen, it.data};
    s_axis_tuser  <= {it.first, it.cmd};
    s_axis_tlast  <= it.fin;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    n = build_frame_bytes(it, seq);
    if (n_typed != 0) begin
      n = n_typed;
      seq = typed;
    end
    for (i = 0; i < n; i++) begin
      frame_byte_q.push_back('{seq[63-8*i -: 8], i == n - 1});
    end
  endtask

  // Random item with every field drawn freely.
  function automatic item_t random_item(input logic cmd);
    item_t it;
    it.cmd   = cmd;
    it.data  = 8'($urandom);
    it.flen  = 8'($urandom);
    it.first = 1'($urandom);
    it.fin   = 1'($urandom);
    return it;
  endfunction

  // Stimulus: directed table, then mostly well-formed frames with some noise.
  initial begin
    item_t       it;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    int unsigned k;
    logic [7:0]  flen;
    int unsigned r;

    // Reset frame, one-byte frames at both length extremes, open frames,
    // stray payload, reset in mid frame with ignored fields set, reopening.
    dir_tab[0]  = '{'{ft12fb_pkg::CmdReset, 8'h00, 8'h00, 1'b0, 1'b0}, 4'd4,
                    64'h10404016_00000000};
    dir_tab[1]  = '{'{ft12fb_pkg::CmdData,  8'h00, 8'h00, 1'b1, 1'b1}, 4'd8,
                    64'h68010168_73007316};
    dir_tab[2]  = '{'{ft12fb_pkg::CmdData,  8'hFF, 8'hFF, 1'b1, 1'b1}, 4'd8,
                    64'h68000068_53FF5216};
    dir_tab[3]  = '{'{ft12fb_pkg::CmdData,  8'h12, 8'h03, 1'b1, 1'b0}, 4'd0, 64'h0};
    dir_tab[4]  = '{'{ft12fb_pkg::CmdData,  8'hAA, 8'h00, 1'b0, 1'b0}, 4'd0, 64'h0};
    dir_tab[5]  = '{'{ft12fb_pkg::CmdData,  8'h55, 8'h00, 1'b0, 1'b1}, 4'd0, 64'h0};
    dir_tab[6]  = '{'{ft12fb_pkg::CmdData,  8'h80, 8'h00, 1'b0, 1'b0}, 4'd0, 64'h0};
    dir_tab[7]  = '{'{ft12fb_pkg::CmdData,  8'h01, 8'hFE, 1'b1, 1'b0}, 4'd0, 64'h0};
    dir_tab[8]  = '{'{ft12fb_pkg::CmdReset, 8'hFF, 8'hFF, 1'b1, 1'b1}, 4'd4,
                    64'h10404016_00000000};
    dir_tab[9]  = '{'{ft12fb_pkg::CmdData,  8'h7F, 8'h00, 1'b0, 1'b1}, 4'd0, 64'h0};
    dir_tab[10] = '{'{ft12fb_pkg::CmdData,  8'hC3, 8'h01, 1'b1, 1'b0}, 4'd0, 64'h0};
    dir_tab[11] = '{'{ft12fb_pkg::CmdData,  8'h3C, 8'h02, 1'b1, 1'b1}, 4'd0, 64'h0};
    dir_tab[12] = '{'{ft12fb_pkg::CmdData,  8'hFF, 8'hFF, 1'b0, 1'b1}, 4'd0, 64'h0};
    dir_tab[13] = '{'{ft12fb_pkg::CmdData,  8'h00, 8'h00, 1'b0, 1'b0}, 4'd0, 64'h0};
    dir_tab[14] = '{'{ft12fb_pkg::CmdData,  8'h5A, 8'h80, 1'b1, 1'b1}, 4'd0, 64'h0};
    dir_tab[15] = '{'{ft12fb_pkg::CmdReset, 8'h00, 8'h00, 1'b0, 1'b0}, 4'd4,
                    64'h10404016_00000000};

    toggle_q = 1'b0;
    sum_q = 8'h00;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < NumDir; r++) begin
      send_item(dir_tab[r].item, dir_tab[r].n_typed, dir_tab[r].typed);
    end

    while (items_sent < NumDir + NumItems) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        send_item(random_item(ft12fb_pkg::CmdReset), 0, 64'h0);
      end else if (pick == 1) begin
        send_item(random_item(ft12fb_pkg::CmdData), 0, 64'h0);
      end else begin
        // Mostly short frames, rarely a long one; some declare a wrong length
        // and some are cut off before their last byte.
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 254) : $urandom_range(1, 8);
        flen = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(len);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
        for (k = 0; k < cut && items_sent < NumDir + NumItems; k++) begin
          it.cmd   = ft12fb_pkg::CmdData;
          it.data  = 8'($urandom);
          it.flen  = (k == 0) ? flen : 8'($urandom);
          it.first = (k == 0);
          it.fin   = (k == len - 1);
          send_item(it, 0, 64'h0);
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (frame_byte_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Output side: random stalls per byte, each transfer checked in order.
  initial begin
    int unsigned gap;
    frame_byte_t want;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 9);
      @(negedge clk_i);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (frame_byte_q.size() == 0) begin
        report_mismatch("unexpected byte", m_axis_tdata, 8'h00);
      end else begin
        want = frame_byte_q.pop_front();
        if (m_axis_tdata !== want.value) begin
          report_mismatch("out_byte", m_axis_tdata, want.value);
        end
        if (m_axis_tlast !== want.run_end) begin
          report_mismatch("run_end", {7'b0, m_axis_tlast}, {7'b0, want.run_end});
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #(5_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
